// ----- sv/nwa_pkg.sv -----
// nwa_pkg: types, step addresses and the control store of the word acceptor sequencer
// depends on nothing; used by nfa_word_acceptor_top
package nwa_pkg;

  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_CLR      = 3'd0;
  localparam upc_t UPC_IDLE     = 3'd1;
  localparam upc_t UPC_ADD_RD   = 3'd2;
  localparam upc_t UPC_ADD_WR   = 3'd3;
  localparam upc_t UPC_SYM_LOOP = 3'd4;
  localparam upc_t UPC_SYM_DONE = 3'd5;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SYM = 1'b1;

  localparam logic CFG_START_STATE = 1'b0;
  localparam logic CFG_FINAL_MASK  = 1'b1;

  localparam int START_W = 4;
  localparam int MASK_W  = 16;

  // sequencing: how the step counter moves
  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_WAIT_ADDR,
    SEQ_WAIT_CNT,
    SEQ_DISPATCH
  } seq_t;

  // address register operation
  typedef enum logic [1:0] {
    ADR_HOLD,
    ADR_INC,
    ADR_STEP,
    ADR_LOAD
  } adr_op_t;

  typedef struct packed {
    seq_t    seq;
    upc_t    target;
    adr_op_t adr;
    logic    capture;
    logic    rd;
    logic    wr_clr;
    logic    wr_add;
    logic    scan;
    logic    acc;
    logic    finish;
  } uword_t;

  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    w = '{seq: SEQ_JUMP, target: UPC_IDLE, adr: ADR_HOLD, capture: 1'b0, rd: 1'b0,
          wr_clr: 1'b0, wr_add: 1'b0, scan: 1'b0, acc: 1'b0, finish: 1'b0};
    unique case (pc)
      UPC_CLR: begin
        w.seq    = SEQ_WAIT_ADDR;
        w.target = UPC_IDLE;
        w.adr    = ADR_INC;
        w.wr_clr = 1'b1;
      end
      UPC_IDLE: begin
        w.seq     = SEQ_DISPATCH;
        w.target  = UPC_SYM_LOOP;
        w.adr     = ADR_LOAD;
        w.capture = 1'b1;
      end
      UPC_ADD_RD: begin
        w.seq = SEQ_NEXT;
        w.rd  = 1'b1;
      end
      UPC_ADD_WR: begin
        w.seq    = SEQ_JUMP;
        w.target = UPC_IDLE;
        w.wr_add = 1'b1;
      end
      UPC_SYM_LOOP: begin
        w.seq    = SEQ_WAIT_CNT;
        w.target = UPC_SYM_DONE;
        w.adr    = ADR_STEP;
        w.rd     = 1'b1;
        w.scan   = 1'b1;
        w.acc    = 1'b1;
      end
      UPC_SYM_DONE: begin
        w.seq    = SEQ_JUMP;
        w.target = UPC_IDLE;
        w.acc    = 1'b1;
        w.finish = 1'b1;
      end
      default: begin
        w.seq    = SEQ_JUMP;
        w.target = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/nfa_word_acceptor_top.sv -----
// nfa_word_acceptor_top: microcoded automaton word acceptor with successor table memory
// depends on nwa_pkg (types, step addresses, control store)
//
// channel   ports                                              handshake
// input     in_op in_from_state in_letter in_to_state          start & !busy
//           in_first_symbol in_last_symbol
// result    out_accepted                                       out_valid strobe, one cycle
// config    cfg_idx cfg_wdata                                  cfg_we, no wait
//
// after reset a clearing pass zeroes all NUM_STATES*NUM_LETTERS table rows, busy high
// add transition steps: accept, row read, row write
// symbol steps: accept, one table row read per state, finish; the single table read port
// makes the rows be read one after another
// a result strobes on out_valid, for a symbol marked last, in the cycle after the finish step, as busy falls;
// the receiver cannot stall
module nfa_word_acceptor_top #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_LETTERS = 26
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_op,
  input  logic [3:0]                in_from_state,
  input  logic [4:0]                in_letter,
  input  logic [3:0]                in_to_state,
  input  logic                      in_first_symbol,
  input  logic                      in_last_symbol,
  output logic                      out_valid,
  output logic                      out_accepted,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [nwa_pkg::MASK_W-1:0] cfg_wdata
);

  localparam int DEPTH  = NUM_STATES * NUM_LETTERS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SI_W   = $clog2(NUM_STATES);

  typedef logic [NUM_STATES-1:0] row_t;

  row_t mem [DEPTH];

  nwa_pkg::upc_t   pc_r, pc_nxt;
  nwa_pkg::uword_t uw;

  logic [ADDR_W-1:0]          addr_r, addr_nxt;
  logic [SI_W-1:0]            cnt_r, cnt_nxt;
  logic [nwa_pkg::START_W-1:0] start_state_r;
  logic [nwa_pkg::MASK_W-1:0]  final_mask_r;
  logic                       ok_r, ok_nxt;
  logic                       last_r;
  logic [3:0]                 to_r;
  row_t                       set_r, set_nxt;
  row_t                       active_r, active_nxt;
  row_t                       acc_r, acc_nxt;
  row_t                       rd_data_r;
  logic                       sel_r;
  logic                       out_valid_r, out_accepted_r;

  logic [63:0]                mask64;
  row_t                       mask_n;
  row_t                       start_set;
  row_t                       picked;
  logic                       letter_ok, add_ok;
  logic [ADDR_W-1:0]          add_addr;
  logic                       mem_we, mem_re;
  row_t                       mem_wdata;

  assign uw        = nwa_pkg::ucode_rom(pc_r);
  assign busy      = (pc_r != nwa_pkg::UPC_IDLE);
  assign out_valid = out_valid_r;
  assign out_accepted = out_accepted_r;

  assign mask64    = 64'(final_mask_r);
  assign mask_n    = mask64[NUM_STATES-1:0];
  assign start_set = (32'(start_state_r) < NUM_STATES) ?
                     (row_t'(1) << start_state_r) : '0;
  assign letter_ok = 32'(in_letter) < NUM_LETTERS;
  assign add_ok    = letter_ok && (32'(in_from_state) < NUM_STATES) &&
                     (32'(in_to_state) < NUM_STATES);
  assign add_addr  = ADDR_W'(32'(in_from_state) * NUM_LETTERS + 32'(in_letter));
  assign picked    = sel_r ? rd_data_r : '0;

  assign mem_re    = uw.rd && ok_r;
  assign mem_we    = uw.wr_clr || (uw.wr_add && ok_r);
  assign mem_wdata = uw.wr_clr ? '0 : (rd_data_r | (row_t'(1) << to_r));

  // step counter
  always_comb begin
    pc_nxt = pc_r;
    unique case (uw.seq)
      nwa_pkg::SEQ_NEXT:      pc_nxt = pc_r + nwa_pkg::upc_t'(1);
      nwa_pkg::SEQ_JUMP:      pc_nxt = uw.target;
      nwa_pkg::SEQ_WAIT_ADDR: pc_nxt = (32'(addr_r) == DEPTH - 1) ? uw.target : pc_r;
      nwa_pkg::SEQ_WAIT_CNT:  pc_nxt = (32'(cnt_r) == NUM_STATES - 1) ? uw.target : pc_r;
      nwa_pkg::SEQ_DISPATCH: begin
        if (start) begin
          pc_nxt = (in_op == nwa_pkg::OP_SYM) ? uw.target : pc_r + nwa_pkg::upc_t'(1);
        end
      end
      default:                pc_nxt = nwa_pkg::UPC_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    ok_nxt     = ok_r;
    set_nxt    = set_r;
    acc_nxt    = acc_r;
    active_nxt = active_r;
    unique case (uw.adr)
      nwa_pkg::ADR_HOLD: addr_nxt = addr_r;
      nwa_pkg::ADR_INC:  addr_nxt = addr_r + ADDR_W'(1);
      nwa_pkg::ADR_STEP: addr_nxt = addr_r + ADDR_W'(NUM_LETTERS);
      nwa_pkg::ADR_LOAD: addr_nxt = (in_op == nwa_pkg::OP_SYM) ?
                                    ADDR_W'(in_letter) : add_addr;
      default:           addr_nxt = addr_r;
    endcase
    if (uw.capture) begin
      cnt_nxt = '0;
      acc_nxt = '0;
      ok_nxt  = (in_op == nwa_pkg::OP_SYM) ? letter_ok : add_ok;
      set_nxt = in_first_symbol ? start_set : active_r;
    end
    if (uw.scan) begin
      cnt_nxt = cnt_r + SI_W'(1);
    end
    if (uw.acc) begin
      acc_nxt = acc_r | picked;
    end
    if (uw.finish) begin
      active_nxt = ok_r ? (acc_r | picked) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r           <= nwa_pkg::UPC_CLR;
      addr_r         <= '0;
      start_state_r  <= '0;
      final_mask_r   <= '0;
      active_r       <= '0;
      sel_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      out_accepted_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      addr_r      <= addr_nxt;
      active_r    <= active_nxt;
      sel_r       <= uw.scan && ok_r && set_r[cnt_r];
      out_valid_r <= uw.finish && last_r;
      if (uw.finish) begin
        out_accepted_r <= |(active_nxt & mask_n);
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          nwa_pkg::CFG_START_STATE: start_state_r <= cfg_wdata[nwa_pkg::START_W-1:0];
          nwa_pkg::CFG_FINAL_MASK:  final_mask_r  <= cfg_wdata;
          default:                  final_mask_r  <= final_mask_r;
        endcase
      end
    end
  end

  // transaction payload and work registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ok_r  <= ok_nxt;
    set_r <= set_nxt;
    acc_r <= acc_nxt;
    if (uw.capture) begin
      last_r <= in_last_symbol;
      to_r   <= in_to_state;
    end
  end

  // successor table, one port shared by read and write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[addr_r];
    end
  end

endmodule

// ----- sim/nfa_word_acceptor_top_tb.sv -----
`timescale 1ns / 1ps
// nfa_word_acceptor_top_tb: self-checking bench for the automaton word acceptor, with a
// queue-fed driver, a result monitor and its own bitset predictor of the verdicts
// depends on nwa_pkg and nfa_word_acceptor_top
module nfa_word_acceptor_top_tb;

  localparam int NSTATES       = 16;
  localparam int NLETTERS      = 26;
  localparam int SETTLE_CYCLES = NSTATES + 8;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 105;
  localparam int NUM_PHASES    = 6;
  localparam int SHOW_LIMIT    = 10;

  typedef struct {
    logic       op;
    logic [3:0] src_state;
    logic [4:0] letter;
    logic [3:0] dst_state;
    logic       is_first;
    logic       is_last;
  } nfa_item_t;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic              busy;
  logic              in_op           = nwa_pkg::OP_ADD;
  logic [3:0]        in_from_state   = '0;
  logic [4:0]        in_letter       = '0;
  logic [3:0]        in_to_state     = '0;
  logic              in_first_symbol = 1'b0;
  logic              in_last_symbol  = 1'b0;
  logic              out_valid;
  logic              out_accepted;
  logic              cfg_we          = 1'b0;
  logic              cfg_idx         = nwa_pkg::CFG_START_STATE;
  logic [nwa_pkg::MASK_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [NSTATES-1:0] succ_rows [NSTATES][NLETTERS];
  logic [NSTATES-1:0] live_set;
  logic [3:0]         model_start;
  logic [NSTATES-1:0] model_final;
  logic               verdict_q [$];

  nfa_item_t pending_items [$];
  int        items_offered  = 0;
  int        items_taken    = 0;
  int        idle_pct       = 24;
  int        quiet_cycles   = 0;
  int        mismatch_count = 0;
  int        n_adds         = 0;
  int        n_symbols      = 0;
  int        n_verdicts     = 0;
  int        n_accepts      = 0;

  nfa_word_acceptor_top #(
    .NUM_STATES (NSTATES),
    .NUM_LETTERS(NLETTERS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_from_state  (in_from_state),
    .in_letter      (in_letter),
    .in_to_state    (in_to_state),
    .in_first_symbol(in_first_symbol),
    .in_last_symbol (in_last_symbol),
    .out_valid      (out_valid),
    .out_accepted   (out_accepted),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [NSTATES-1:0] follow_letter(logic [NSTATES-1:0] from_set,
                                                       logic [4:0] letter);
    logic [NSTATES-1:0] reach;
    reach = '0;
    if (letter < NLETTERS) begin
      for (int s = 0; s < NSTATES; s++) begin
        if (from_set[s]) begin
          reach |= succ_rows[s][letter];
        end
      end
    end
    return reach;
  endfunction

  function automatic void absorb_item(nfa_item_t it);
    logic [NSTATES-1:0] base;
    base = '0;
    if (it.op == nwa_pkg::OP_ADD) begin
      n_adds++;
      if (it.letter < NLETTERS) begin
        succ_rows[it.src_state][it.letter][it.dst_state] = 1'b1;
      end
    end else begin
      n_symbols++;
      if (it.is_first) begin
        base[model_start] = 1'b1;
      end else begin
        base = live_set;
      end
      live_set = follow_letter(base, it.letter);
      if (it.is_last) begin
        verdict_q.push_back(|(live_set & model_final));
      end
    end
  endfunction

  function automatic void log_mismatch(string what, logic want, logic got);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT) begin
      $display("%0t mismatch: %s, expected accepted=%b got %b", $time, what, want, got);
    end
  endfunction

  // mostly a small alphabet so the table fills up, now and then the extremes
  function automatic logic [4:0] pick_letter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 5'($urandom_range(0, 3));
    end else if (r < 90) begin
      return 5'($urandom_range(0, NLETTERS - 1));
    end else if (r < 95) begin
      return 5'(NLETTERS - 1);
    end
    return 5'($urandom_range(NLETTERS, 31));
  endfunction

  function automatic void add_edge(logic [3:0] src, logic [4:0] letter, logic [3:0] dst);
    nfa_item_t it;
    it.op        = nwa_pkg::OP_ADD;
    it.src_state = src;
    it.letter    = letter;
    it.dst_state = dst;
    it.is_first  = 1'($urandom);
    it.is_last   = 1'($urandom);
    pending_items.push_back(it);
  endfunction

  function automatic void feed_symbol(logic [4:0] letter, logic is_first, logic is_last);
    nfa_item_t it;
    it.op        = nwa_pkg::OP_SYM;
    it.src_state = 4'($urandom);
    it.letter    = letter;
    it.dst_state = 4'($urandom);
    it.is_first  = is_first;
    it.is_last   = is_last;
    pending_items.push_back(it);
  endfunction

  task automatic write_cfg(logic idx, logic [nwa_pkg::MASK_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    if (idx == nwa_pkg::CFG_START_STATE) begin
      model_start = value[3:0];
    end else begin
      model_final = value[NSTATES-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every transaction is taken and answered, then let the block go idle
  task automatic drain_block();
    while (pending_items.size() != 0 || items_taken != items_offered ||
           verdict_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (items_taken == items_offered) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_op           <= pending_items[0].op;
        in_from_state   <= pending_items[0].src_state;
        in_letter       <= pending_items[0].letter;
        in_to_state     <= pending_items[0].dst_state;
        in_first_symbol <= pending_items[0].is_first;
        in_last_symbol  <= pending_items[0].is_last;
        start           <= 1'b1;
        items_offered   <= items_offered + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    nfa_item_t taken;
    logic      want;
    if (rst_n) begin
      if (start && !busy) begin
        taken = pending_items.pop_front();
        absorb_item(taken);
        items_taken <= items_taken + 1;
      end
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          log_mismatch("result with no transaction waiting", 1'bx, out_accepted);
        end else begin
          want = verdict_q.pop_front();
          n_verdicts++;
          if (want) begin
            n_accepts++;
          end
          if (out_accepted !== want) begin
            log_mismatch("word verdict", want, out_accepted);
          end
        end
      end
      quiet_cycles <= ((start && !busy) || out_valid) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles, %0d verdicts outstanding",
             QUIET_LIMIT, verdict_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int         phase_items;
    int         word_len;
    logic [3:0] st;
    logic       no_first;
    logic       no_last;

    for (int s = 0; s < NSTATES; s++) begin
      for (int l = 0; l < NLETTERS; l++) begin
        succ_rows[s][l] = '0;
      end
    end
    live_set    = '0;
    model_start = '0;
    model_final = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // table clearing pass after reset
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);

    write_cfg(nwa_pkg::CFG_START_STATE, 16'h0000);
    write_cfg(nwa_pkg::CFG_FINAL_MASK, 16'h8004);

    // directed: small automaton with nondeterminism and the range extremes
    add_edge(4'd0, 5'd0, 4'd1);
    add_edge(4'd1, 5'd1, 4'd2);
    add_edge(4'd0, 5'd0, 4'd0);
    add_edge(4'd15, 5'd25, 4'd15);
    add_edge(4'd2, 5'd25, 4'd15);
    add_edge(4'd15, 5'd31, 4'd3);
    add_edge(4'd15, 5'd26, 4'd0);
    feed_symbol(5'd0, 1'b1, 1'b1);
    feed_symbol(5'd0, 1'b1, 1'b0);
    feed_symbol(5'd1, 1'b0, 1'b1);
    // continue after the word ended
    feed_symbol(5'd25, 1'b0, 1'b1);
    feed_symbol(5'd25, 1'b0, 1'b1);
    feed_symbol(5'd31, 1'b1, 1'b1);
    // letter out of range mid-word empties the set
    feed_symbol(5'd0, 1'b1, 1'b0);
    feed_symbol(5'd27, 1'b0, 1'b0);
    feed_symbol(5'd0, 1'b0, 1'b1);
    feed_symbol(5'd0, 1'b1, 1'b1);
    add_edge(4'd0, 5'd25, 4'd15);
    feed_symbol(5'd25, 1'b1, 1'b1);
    drain_block();

    write_cfg(nwa_pkg::CFG_START_STATE, 16'hfff0 | 16'd15);
    write_cfg(nwa_pkg::CFG_FINAL_MASK, 16'hffff);
    feed_symbol(5'd25, 1'b1, 1'b1);
    feed_symbol(5'd0, 1'b1, 1'b1);
    drain_block();

    // random phases: sender idles 24%, then 61%, then not at all
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = (ph < 2) ? 24 : (ph < 4) ? 61 : 0;
      unique case (ph)
        1: begin
          st = 4'd15;
          write_cfg(nwa_pkg::CFG_FINAL_MASK, 16'hffff);
        end
        2: begin
          st = 4'd0;
          write_cfg(nwa_pkg::CFG_FINAL_MASK, 16'h0000);
        end
        3: begin
          st = 4'($urandom);
          write_cfg(nwa_pkg::CFG_FINAL_MASK, 16'h0001 << $urandom_range(0, 15));
        end
        5: begin
          st = 4'd0;
          write_cfg(nwa_pkg::CFG_FINAL_MASK, 16'h8001);
        end
        default: begin
          st = 4'($urandom);
          write_cfg(nwa_pkg::CFG_FINAL_MASK, 16'($urandom));
        end
      endcase
      write_cfg(nwa_pkg::CFG_START_STATE, {12'($urandom), st});

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 30) begin
          repeat ($urandom_range(1, 3)) begin
            add_edge(4'($urandom), pick_letter(), 4'($urandom));
            phase_items++;
          end
        end else begin
          word_len = $urandom_range(1, 6);
          no_first = ($urandom_range(0, 99) < 10);
          no_last  = ($urandom_range(0, 99) < 5);
          for (int k = 0; k < word_len; k++) begin
            feed_symbol(pick_letter(), (k == 0) && !no_first,
                        (k == word_len - 1) && !no_last);
            phase_items++;
          end
        end
      end
      drain_block();
    end

    $display("covered %0d transactions: %0d transition adds, %0d symbols",
             items_taken, n_adds, n_symbols);
    $display("checked %0d word verdicts, %0d accepted, %0d mismatches",
             n_verdicts, n_accepts, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- nfa_word_acceptor_top.f -----
sv/nwa_pkg.sv
sv/nfa_word_acceptor_top.sv
sim/nfa_word_acceptor_top_tb.sv
